[rtl/u2a_pkg.sv]
// Shared types, character codes and folding functions of the UTF-8 to ASCII block.
// Used by u2a_front, u2a_op_queue, u2a_back and the top level; no dependencies.
package u2a_pkg;

   localparam int OP_QUEUE_DEPTH_DEF = 4;

   localparam logic [6:0] CH_SPACE = 7'h20;
   localparam logic [6:0] CH_PLUS  = 7'h2B;
   localparam logic [6:0] CH_A     = 7'h61;
   localparam logic [6:0] CH_C     = 7'h63;
   localparam logic [6:0] CH_D     = 7'h64;
   localparam logic [6:0] CH_E     = 7'h65;
   localparam logic [6:0] CH_H     = 7'h68;
   localparam logic [6:0] CH_I     = 7'h69;
   localparam logic [6:0] CH_L     = 7'h6C;
   localparam logic [6:0] CH_N     = 7'h6E;
   localparam logic [6:0] CH_O     = 7'h6F;
   localparam logic [6:0] CH_S     = 7'h73;
   localparam logic [6:0] CH_T     = 7'h74;
   localparam logic [6:0] CH_U     = 7'h75;
   localparam logic [6:0] CH_Y     = 7'h79;
   localparam logic [6:0] CH_Z     = 7'h7A;
   localparam logic [6:0] CH_NUL   = 7'h00;

   localparam logic [7:0] LEAD2_MASK = 8'hE0;
   localparam logic [7:0] LEAD2_CODE = 8'hC0;
   localparam logic [7:0] LEAD3_MASK = 8'hF0;
   localparam logic [7:0] LEAD3_CODE = 8'hE0;
   localparam logic [7:0] LEAD4_MASK = 8'hF8;
   localparam logic [7:0] LEAD4_CODE = 8'hF0;

   // One token expands to a fixed character run.
   typedef enum logic [2:0] {
      TK_NONE = 3'd0,
      TK_CHAR = 3'd1,
      TK_AMP  = 3'd2,
      TK_TH   = 3'd3,
      TK_SS   = 3'd4
   } tok_kind_type;

   typedef struct packed {
      tok_kind_type kind;
      logic [6:0]   ch;
   } token_type;

   // One queue word: up to two tokens from one input byte. tok0 empty marks an end marker.
   typedef struct packed {
      token_type tok0;
      token_type tok1;
      logic      last;
   } entry_type;

   typedef struct packed {
      logic [6:0] ch;
      logic       valid;
      logic       last;
   } result_type;

   localparam token_type TOK_NONE = '{kind: TK_NONE, ch: CH_NUL};

   function automatic token_type char_token(input logic [6:0] c);
      token_type t;
      t.kind = TK_CHAR;
      t.ch   = c;
      return t;
   endfunction

   function automatic token_type kind_token(input tok_kind_type k);
      token_type t;
      t.kind = k;
      t.ch   = CH_NUL;
      return t;
   endfunction

   function automatic token_type ascii_token(input logic [6:0] c);
      token_type t;
      t = TOK_NONE;
      if ((c >= 7'h41 && c <= 7'h5A) || (c >= 7'h61 && c <= 7'h7A) ||
          (c >= 7'h30 && c <= 7'h39) || c == CH_SPACE || c == CH_PLUS) begin
         t = char_token(c);
      end else if (c == 7'h5F || c == 7'h2D || c == 7'h2E || c == 7'h2F ||
                   c == 7'h5C || c == 7'h7C) begin
         t = char_token(CH_SPACE);
      end else if (c == 7'h26) begin
         t = kind_token(TK_AMP);
      end
      return t;
   endfunction

   function automatic logic [2:0] lead_len(input logic [7:0] b);
      logic [2:0] n;
      n = 3'd0;
      if ((b & LEAD2_MASK) == LEAD2_CODE) n = 3'd2;
      else if ((b & LEAD3_MASK) == LEAD3_CODE) n = 3'd3;
      else if ((b & LEAD4_MASK) == LEAD4_CODE) n = 3'd4;
      return n;
   endfunction

   // cnt is the number of held bytes; the current byte completes the sequence.
   function automatic logic [20:0] decode_cp(input logic [7:0] h0, input logic [7:0] h1,
                                             input logic [7:0] h2, input logic [7:0] b,
                                             input logic [1:0] cnt);
      logic [20:0] cp;
      case (cnt)
         2'd1:    cp = {10'd0, h0[4:0], b[5:0]};
         2'd2:    cp = {5'd0, h0[3:0], h1[5:0], b[5:0]};
         2'd3:    cp = {h0[2:0], h1[5:0], h2[5:0], b[5:0]};
         default: cp = {18'd0, b[2:0]};
      endcase
      return cp;
   endfunction

   function automatic token_type fold_token(input logic [20:0] cp);
      token_type t;
      t = TOK_NONE;
      if (cp[20:8] == 13'd0 && cp[7:6] == 2'b11) begin
         // Latin-1 letters; both case halves fold alike except the last slot
         case (cp[4:0]) inside
            [5'h00:5'h06]: t = char_token(CH_A);
            5'h07:         t = char_token(CH_C);
            [5'h08:5'h0B]: t = char_token(CH_E);
            [5'h0C:5'h0F]: t = char_token(CH_I);
            5'h11:         t = char_token(CH_N);
            [5'h12:5'h16]: t = char_token(CH_O);
            5'h18:         t = char_token(CH_O);
            [5'h19:5'h1C]: t = char_token(CH_U);
            5'h1D:         t = char_token(CH_Y);
            5'h1E:         t = kind_token(TK_TH);
            5'h1F:         t = cp[5] ? char_token(CH_Y) : kind_token(TK_SS);
            default:       t = TOK_NONE;
         endcase
      end else if (cp[20:8] == 13'd1) begin
         case (cp[7:0]) inside
            8'h04, 8'h05:                      t = char_token(CH_A);
            8'h06, 8'h07, 8'h0C, 8'h0D:        t = char_token(CH_C);
            8'h10, 8'h11:                      t = char_token(CH_D);
            8'h18, 8'h19:                      t = char_token(CH_E);
            8'h41, 8'h42:                      t = char_token(CH_L);
            8'h43, 8'h44, 8'h47, 8'h48:        t = char_token(CH_N);
            8'h5A, 8'h5B, [8'h5E:8'h61]:       t = char_token(CH_S);
            8'h78:                             t = char_token(CH_Y);
            [8'h79:8'h7E]:                     t = char_token(CH_Z);
            default:                           t = TOK_NONE;
         endcase
      end
      return t;
   endfunction

   function automatic logic [2:0] tok_len(input tok_kind_type k);
      logic [2:0] n;
      case (k)
         TK_CHAR: n = 3'd1;
         TK_AMP:  n = 3'd5;
         TK_TH:   n = 3'd2;
         TK_SS:   n = 3'd2;
         default: n = 3'd0;
      endcase
      return n;
   endfunction

   function automatic logic [6:0] tok_char(input token_type t, input logic [2:0] idx);
      logic [6:0] c;
      case (t.kind)
         TK_CHAR: c = t.ch;
         TK_AMP: begin
            case (idx)
               3'd1:    c = CH_A;
               3'd2:    c = CH_N;
               3'd3:    c = CH_D;
               default: c = CH_SPACE;
            endcase
         end
         TK_TH:   c = (idx == 3'd0) ? CH_T : CH_H;
         TK_SS:   c = CH_S;
         default: c = CH_NUL;
      endcase
      return c;
   endfunction

endpackage

[rtl/u2a_front.sv]
// Front end: takes bytes, tracks the open UTF-8 sequence and turns each byte into tokens.
// Depends on u2a_pkg.
module u2a_front import u2a_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       take,
   input  logic [7:0] in_byte,
   input  logic       in_last,
   output logic       q_push,
   output entry_type  q_entry
);

   logic [7:0] held_ff [3];
   logic [7:0] held_in [3];
   logic [1:0] cnt_ff, cnt_in;
   logic [2:0] len_ff, len_in;
   logic [2:0] lead;
   token_type  tok_a, tok_b;
   logic [7:0] t0;

   always_comb begin
      held_in = held_ff;
      cnt_in  = cnt_ff;
      len_in  = len_ff;
      tok_a   = TOK_NONE;
      tok_b   = TOK_NONE;
      lead    = lead_len(in_byte);
      t0      = held_ff[1];
      if (len_ff == 3'd0) begin
         if (!in_byte[7]) begin
            tok_a = ascii_token(in_byte[6:0]);
         end else if (lead != 3'd0) begin
            held_in[0] = in_byte;
            cnt_in     = 2'd1;
            len_in     = lead;
         end
      end else if ({1'b0, cnt_ff} + 3'd1 >= len_ff || cnt_ff == 2'd3) begin
         tok_a  = fold_token(decode_cp(held_ff[0], held_ff[1], held_ff[2], in_byte, cnt_ff));
         cnt_in = 2'd0;
         len_in = 3'd0;
      end else begin
         held_in[cnt_ff] = in_byte;
         cnt_in          = cnt_ff + 2'd1;
         // string ends inside a sequence: drop the lead, rerun what follows it
         if (in_last) begin
            if (cnt_ff == 2'd1) begin
               if (!in_byte[7]) tok_a = ascii_token(in_byte[6:0]);
            end else begin
               if (!t0[7]) begin
                  tok_a = ascii_token(t0[6:0]);
                  if (!in_byte[7]) tok_b = ascii_token(in_byte[6:0]);
               end else if (lead_len(t0) == 3'd2) begin
                  tok_a = fold_token(decode_cp(t0, 8'd0, 8'd0, in_byte, 2'd1));
               end else if (!in_byte[7]) begin
                  tok_a = ascii_token(in_byte[6:0]);
               end
            end
         end
      end
      if (in_last) begin
         cnt_in = 2'd0;
         len_in = 3'd0;
      end
   end

   always_comb begin
      if (tok_a.kind == TK_NONE) begin
         q_entry.tok0 = tok_b;
         q_entry.tok1 = TOK_NONE;
      end else begin
         q_entry.tok0 = tok_a;
         q_entry.tok1 = tok_b;
      end
      q_entry.last = in_last;
      q_push = take && (tok_a.kind != TK_NONE || tok_b.kind != TK_NONE || in_last);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         len_ff <= 3'd0;
      end else if (take) begin
         cnt_ff <= cnt_in;
         len_ff <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         held_ff <= held_in;
      end
   end

endmodule

[rtl/u2a_op_queue.sv]
// Short FIFO of token words between the front end and the expander.
// Depends on u2a_pkg.
module u2a_op_queue import u2a_pkg::*; #(
   parameter int DEPTH = OP_QUEUE_DEPTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      wr_en,
   input  entry_type wr_data,
   input  logic      rd_en,
   output entry_type rd_data,
   output logic      full,
   output logic      empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   entry_type         mem_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]     count_ff;
   logic              do_wr, do_rd;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
      return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_wr) wr_ptr_ff <= next_ptr(wr_ptr_ff);
         if (do_rd) rd_ptr_ff <= next_ptr(rd_ptr_ff);
         if (do_wr && !do_rd) count_ff <= count_ff + 1'b1;
         else if (do_rd && !do_wr) count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

[rtl/u2a_back.sv]
// Back end: expands token words into a two-word result FIFO, one character per cycle while it has room.
// Depends on u2a_pkg.
module u2a_back import u2a_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  entry_type  q_head,
   input  logic       q_empty,
   output logic       q_pop,
   input  logic       pop,
   output logic       empty,
   output result_type rsp
);

   entry_type  cur_ff;
   logic       cur_valid_ff;
   logic       sel_ff;
   logic [2:0] idx_ff;
   result_type omem_ff [2];
   logic       owr_ff, ord_ff;
   logic [1:0] ocnt_ff;

   token_type  cur_tok;
   logic [2:0] cur_len;
   logic       marker, tok_end, final_char;
   logic       emit, load, out_pop;
   result_type res;

   always_comb begin
      cur_tok    = sel_ff ? cur_ff.tok1 : cur_ff.tok0;
      cur_len    = tok_len(cur_tok.kind);
      marker     = (cur_ff.tok0.kind == TK_NONE);
      tok_end    = (idx_ff == cur_len - 3'd1);
      final_char = marker || (tok_end && (sel_ff || cur_ff.tok1.kind == TK_NONE));
      emit       = cur_valid_ff && (ocnt_ff != 2'd2);
      load       = !cur_valid_ff || (emit && final_char);
      q_pop      = load && !q_empty;
      res.ch     = marker ? CH_NUL : tok_char(cur_tok, idx_ff);
      res.valid  = !marker;
      res.last   = final_char && cur_ff.last;
   end

   assign out_pop = pop && (ocnt_ff != 2'd0);
   assign empty   = (ocnt_ff == 2'd0);
   assign rsp     = omem_ff[ord_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         sel_ff       <= 1'b0;
         idx_ff       <= 3'd0;
         owr_ff       <= 1'b0;
         ord_ff       <= 1'b0;
         ocnt_ff      <= 2'd0;
      end else begin
         if (load) begin
            cur_valid_ff <= !q_empty;
            sel_ff       <= 1'b0;
            idx_ff       <= 3'd0;
         end else if (emit) begin
            if (tok_end) begin
               sel_ff <= 1'b1;
               idx_ff <= 3'd0;
            end else begin
               idx_ff <= idx_ff + 3'd1;
            end
         end
         if (emit) owr_ff <= !owr_ff;
         if (out_pop) ord_ff <= !ord_ff;
         if (emit && !out_pop) ocnt_ff <= ocnt_ff + 2'd1;
         else if (out_pop && !emit) ocnt_ff <= ocnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) cur_ff <= q_head;
      if (emit) omem_ff[owr_ff] <= res;
   end

endmodule

[rtl/utf8_to_ascii_transliterator.sv]
// Top level of the UTF-8 to ASCII transliterator.
// Depends on u2a_pkg, u2a_front, u2a_op_queue and u2a_back.

// Bytes of a UTF-8 string go in on push/full, one per cycle while full is low, and folded ASCII
// characters come out on empty/pop, one per cycle, with rsp_out_last on the final word of each
// string (a word with rsp_out_valid low and a zero character when the string's last byte gave
// nothing). The front end takes a byte every cycle while the op queue is not full; the expander
// gives one character per cycle while its result FIFO has room, so a byte that yields several
// characters (five for an ampersand, two for ss or th, up to ten for a tail reprocessed at the
// end of a string) holds the request side once the OP_QUEUE_DEPTH-word op queue has filled.
module utf8_to_ascii_transliterator import u2a_pkg::*; #(
   parameter int OP_QUEUE_DEPTH = OP_QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       empty,
   input  logic       pop,
   output logic [6:0] rsp_out_char,
   output logic       rsp_out_valid,
   output logic       rsp_out_last
);

   logic       take;
   logic       q_push, q_pop, q_full, q_empty;
   entry_type  q_wr, q_head;
   result_type rsp;

   assign full = q_full;
   assign take = push && !q_full;

   u2a_front u_front (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .in_byte (req_in_byte),
      .in_last (req_in_last),
      .q_push  (q_push),
      .q_entry (q_wr)
   );

   u2a_op_queue #(.DEPTH(OP_QUEUE_DEPTH)) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_data (q_wr),
      .rd_en   (q_pop),
      .rd_data (q_head),
      .full    (q_full),
      .empty   (q_empty)
   );

   u2a_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_head  (q_head),
      .q_empty (q_empty),
      .q_pop   (q_pop),
      .pop     (pop),
      .empty   (empty),
      .rsp     (rsp)
   );

   assign rsp_out_char  = rsp.ch;
   assign rsp_out_valid = rsp.valid;
   assign rsp_out_last  = rsp.last;

   // an end marker always closes its string and carries no character
   a_marker_last: assert property (@(posedge clock) disable iff (reset)
      !empty && !rsp_out_valid |-> rsp_out_last && rsp_out_char == CH_NUL)
      else $error("end marker without last or with a character");

   a_char_nonzero: assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_out_valid |-> rsp_out_char != CH_NUL)
      else $error("valid result word carries a null character");

   a_queue_idle: assert property (@(posedge clock) disable iff (reset)
      q_empty && !q_push |=> q_empty)
      else $error("op queue filled without a push");

endmodule
